FILE: rtl/mop_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mop_pkg
// Shared types, constants and helpers of the Mandelbrot orbit plotter.
// ----------------------------------------------------------------------------
package mop_pkg;

    // fixed-point format and plot mapping
    localparam int FRAC_BITS  = 27;
    localparam int PLOT_SCALE = 250;
    localparam int SCREEN_MAX = 4096;

    // color polynomial weights (9, 15 and 17 times 255; the blue product is halved once more, giving 8.5)
    localparam int RED_WEIGHT   = 2295;
    localparam int GREEN_WEIGHT = 3825;
    localparam int BLUE_WEIGHT  = 4335;

    // divider length: one quotient bit per step, Q0.16 result
    localparam int DIV_STEPS = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_PLOT = 2'd0;
    localparam logic [1:0] STAT_OFF  = 2'd1;
    localparam logic [1:0] STAT_ESC  = 2'd2;
    localparam logic [1:0] STAT_IDLE = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_IDLE_RES,
        OP_SQ_RR,
        OP_SQ_II,
        OP_SQ_RI,
        OP_ZNEW,
        OP_MAG_R,
        OP_MAG_I,
        OP_ESC,
        OP_CNT,
        OP_PIX_X,
        OP_PIX_Y,
        OP_DIV,
        OP_UT,
        OP_TT,
        OP_UU,
        OP_PR,
        OP_PG,
        OP_PB,
        OP_CR,
        OP_CG,
        OP_CB
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RR,
        ST_II,
        ST_RI,
        ST_ZNEW,
        ST_MR,
        ST_MI,
        ST_ESC,
        ST_PX,
        ST_PY,
        ST_DIV,
        ST_UT,
        ST_TT,
        ST_UU,
        ST_PR,
        ST_PG,
        ST_PB,
        ST_CR,
        ST_CG,
        ST_CB,
        ST_WRITE
    } state_t;

    typedef struct packed {
        op_t  op;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic escape;
        logic at_limit;
    } stat_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -65'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // clamp a color channel to one byte
    function automatic logic [7:0] clamp255(input logic [31:0] v);
        logic [7:0] r;
        r = (v > 32'd255) ? 8'd255 : v[7:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mop_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mop_dp
// Datapath: orbit state, shared multiplier, divider, pixel map, result regs.
// ----------------------------------------------------------------------------
module mop_dp (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mop_pkg::cmd_t       cmd,
    output mop_pkg::stat_t      stat,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [15:0]         cfg_data,
    input  wire  signed [31:0]  in_real,
    input  wire  signed [31:0]  in_imag,
    output logic [1:0]          out_status,
    output logic [11:0]         out_x,
    output logic [11:0]         out_y,
    output logic [23:0]         out_color,
    output logic                out_done
);
    import mop_pkg::*;

    logic [15:0]        limit_reg;
    logic [12:0]        width_reg;
    logic [12:0]        height_reg;
    logic signed [31:0] zr_reg, zi_reg, cr_reg, ci_reg;
    logic [15:0]        cnt_reg;
    logic               active_reg;
    logic               lim_reg;

    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic [31:0]        h0_reg, h1_reg, h2_reg;
    logic [15:0]        rem_reg, q_reg;
    logic [11:0]        xq_reg;
    logic               xok_reg;

    logic [1:0]         res_status_reg;
    logic [11:0]        res_x_reg, res_y_reg;
    logic [23:0]        res_color_reg;
    logic               res_done_reg;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [63:0] mul_lo;
    logic [16:0]        u_val;

    assign u_val = 17'd65536 - {1'b0, q_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ_RR, OP_MAG_R:
            begin
                mul_a = 34'(zr_reg);
                mul_b = 34'(zr_reg);
            end
            OP_SQ_II, OP_MAG_I:
            begin
                mul_a = 34'(zi_reg);
                mul_b = 34'(zi_reg);
            end
            OP_SQ_RI:
            begin
                mul_a = 34'(zr_reg);
                mul_b = 34'(zi_reg);
            end
            OP_PIX_X:
            begin
                mul_a = 34'(zr_reg);
                mul_b = 34'(PLOT_SCALE);
            end
            OP_PIX_Y:
            begin
                mul_a = 34'(zi_reg);
                mul_b = 34'(PLOT_SCALE);
            end
            OP_UT:
            begin
                mul_a = {17'd0, u_val};
                mul_b = {18'd0, q_reg};
            end
            OP_TT:
            begin
                mul_a = {18'd0, q_reg};
                mul_b = {18'd0, q_reg};
            end
            OP_UU:
            begin
                mul_a = {17'd0, u_val};
                mul_b = {17'd0, u_val};
            end
            OP_PR:
            begin
                mul_a = {1'b0, p0_reg[32:0]};
                mul_b = {1'b0, p1_reg[32:0]};
            end
            OP_PG:
            begin
                mul_a = {1'b0, p2_reg[32:0]};
                mul_b = {1'b0, p1_reg[32:0]};
            end
            OP_PB:
            begin
                mul_a = {1'b0, p2_reg[32:0]};
                mul_b = {1'b0, p0_reg[32:0]};
            end
            OP_CR:
            begin
                mul_a = {2'd0, h0_reg};
                mul_b = 34'(RED_WEIGHT);
            end
            OP_CG:
            begin
                mul_a = {2'd0, h1_reg};
                mul_b = 34'(GREEN_WEIGHT);
            end
            OP_CB:
            begin
                mul_a = {2'd0, h2_reg};
                mul_b = 34'(BLUE_WEIGHT);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign mul_lo = mul_p[63:0];

    // next z: floor-shifted products plus c, saturated
    logic signed [64:0] re_diff, re_sum, im_sum;
    assign re_diff = 65'(p0_reg) - 65'(p1_reg);
    assign re_sum  = (re_diff >>> FRAC_BITS) + 65'(cr_reg);
    assign im_sum  = (65'(p2_reg) >>> (FRAC_BITS - 1)) + 65'(ci_reg);

    // escape test on the squared magnitudes
    logic [64:0] mag2;
    assign mag2        = {1'b0, p0_reg} + {1'b0, p1_reg};
    assign stat.escape = mag2 > (65'd1 << (2 * FRAC_BITS + 2));
    assign stat.active = active_reg;
    assign stat.at_limit = lim_reg;

    // counter advance
    logic [15:0] cnt_inc;
    logic        at_lim;
    assign cnt_inc = cnt_reg + 16'd1;
    assign at_lim  = cnt_inc >= limit_reg;

    // pixel map, truncating toward zero
    logic [12:0]        w_eff, h_eff, pix_size;
    logic signed [63:0] pix_a, pix_v, pix_q;
    logic               pix_ok;

    assign w_eff = (width_reg  > 13'(SCREEN_MAX)) ? 13'(SCREEN_MAX) : width_reg;
    assign h_eff = (height_reg > 13'(SCREEN_MAX)) ? 13'(SCREEN_MAX) : height_reg;

    always_comb
    begin
        if (cmd.op == OP_PIX_Y)
        begin
            pix_a    = -mul_lo;
            pix_size = h_eff;
        end
        else
        begin
            pix_a    = mul_lo;
            pix_size = w_eff;
        end
        pix_v = pix_a + (signed'(64'(pix_size >> 1)) <<< FRAC_BITS);
        if (pix_v < 0)
            pix_q = (pix_v + signed'((64'd1 << FRAC_BITS) - 64'd1)) >>> FRAC_BITS;
        else
            pix_q = pix_v >>> FRAC_BITS;
        pix_ok = !pix_q[63] && (pix_q < signed'(64'(pix_size)));
    end

    // restoring divider step
    logic [16:0] div_r2;
    logic        div_ge;
    assign div_r2 = {rem_reg, 1'b0};
    assign div_ge = div_r2 >= {1'b0, limit_reg};

    // configuration, orbit state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= 16'd500;
            width_reg      <= 13'd800;
            height_reg     <= 13'd600;
            zr_reg         <= '0;
            zi_reg         <= '0;
            cr_reg         <= '0;
            ci_reg         <= '0;
            cnt_reg        <= '0;
            active_reg     <= 1'b0;
            lim_reg        <= 1'b0;
            res_status_reg <= STAT_IDLE;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_color_reg  <= '0;
            res_done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LIMIT:  limit_reg  <= cfg_data;
                    CFG_WIDTH:  width_reg  <= cfg_data[12:0];
                    CFG_HEIGHT: height_reg <= cfg_data[12:0];
                    default:    ;
                endcase
            end
            case (cmd.op)
                OP_START:
                begin
                    cr_reg         <= in_real;
                    ci_reg         <= in_imag;
                    zr_reg         <= '0;
                    zi_reg         <= '0;
                    cnt_reg        <= '0;
                    active_reg     <= 1'b1;
                    res_status_reg <= STAT_IDLE;
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                    res_color_reg  <= '0;
                    res_done_reg   <= 1'b0;
                end
                OP_IDLE_RES:
                begin
                    res_status_reg <= STAT_IDLE;
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                    res_color_reg  <= '0;
                    res_done_reg   <= 1'b0;
                end
                OP_ZNEW:
                begin
                    zr_reg <= sat32(re_sum);
                    zi_reg <= sat32(im_sum);
                end
                OP_ESC:
                begin
                    active_reg     <= 1'b0;
                    res_status_reg <= STAT_ESC;
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                    res_color_reg  <= '0;
                    res_done_reg   <= 1'b1;
                end
                OP_CNT:
                begin
                    cnt_reg       <= cnt_inc;
                    lim_reg       <= at_lim;
                    res_done_reg  <= at_lim;
                    res_color_reg <= '0;
                    if (at_lim)
                        active_reg <= 1'b0;
                end
                OP_PIX_Y:
                begin
                    if (xok_reg && pix_ok)
                    begin
                        res_status_reg <= STAT_PLOT;
                        res_x_reg      <= xq_reg;
                        res_y_reg      <= pix_q[11:0];
                    end
                    else
                    begin
                        res_status_reg <= STAT_OFF;
                        res_x_reg      <= '0;
                        res_y_reg      <= '0;
                    end
                end
                OP_CR: res_color_reg[23:16] <= clamp255(mul_lo[63:32]);
                OP_CG: res_color_reg[15:8]  <= clamp255(mul_lo[63:32]);
                OP_CB: res_color_reg[7:0]   <= clamp255({1'b0, mul_lo[63:33]});
                default: ;
            endcase
        end
    end

    // working products and divider
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SQ_RR, OP_MAG_R, OP_UT: p0_reg <= mul_lo;
            OP_SQ_II, OP_MAG_I, OP_TT: p1_reg <= mul_lo;
            OP_SQ_RI, OP_UU:           p2_reg <= mul_lo;
            OP_PR: h0_reg <= mul_lo[63:32];
            OP_PG: h1_reg <= mul_lo[63:32];
            OP_PB: h2_reg <= mul_lo[63:32];
            OP_CNT:
            begin
                rem_reg <= cnt_inc;
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= div_ge ? 16'(div_r2 - {1'b0, limit_reg}) : div_r2[15:0];
                q_reg   <= {q_reg[14:0], div_ge};
            end
            OP_PIX_X:
            begin
                xq_reg  <= pix_q[11:0];
                xok_reg <= pix_ok;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status <= res_status_reg;
            out_x      <= res_x_reg;
            out_y      <= res_y_reg;
            out_color  <= res_color_reg;
            out_done   <= res_done_reg;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/mop_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mop_ctrl
// Controller: sequences the datapath for each item and runs the handshakes.
// ----------------------------------------------------------------------------
module mop_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    output logic            s_tready,
    input  wire             kind,
    output logic            m_tvalid,
    input  wire             m_tready,
    input  mop_pkg::stat_t  stat,
    output mop_pkg::cmd_t   cmd
);
    import mop_pkg::*;

    localparam int DIV_W = $clog2(DIV_STEPS);

    state_t             state_reg, state_next;
    logic [DIV_W-1:0]   div_cnt_reg, div_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // hold state, divider count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd.op       = OP_NONE;
        cmd.load_out = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!kind)
                    begin
                        cmd.op     = OP_START;
                        state_next = ST_WRITE;
                    end
                    else if (!stat.active)
                    begin
                        cmd.op     = OP_IDLE_RES;
                        state_next = ST_WRITE;
                    end
                    else
                        state_next = ST_RR;
                end
            end
            ST_RR:   begin cmd.op = OP_SQ_RR; state_next = ST_II;   end
            ST_II:   begin cmd.op = OP_SQ_II; state_next = ST_RI;   end
            ST_RI:   begin cmd.op = OP_SQ_RI; state_next = ST_ZNEW; end
            ST_ZNEW: begin cmd.op = OP_ZNEW;  state_next = ST_MR;   end
            ST_MR:   begin cmd.op = OP_MAG_R; state_next = ST_MI;   end
            ST_MI:   begin cmd.op = OP_MAG_I; state_next = ST_ESC;  end
            ST_ESC:
            begin
                if (stat.escape)
                begin
                    cmd.op     = OP_ESC;
                    state_next = ST_WRITE;
                end
                else
                begin
                    cmd.op     = OP_CNT;
                    state_next = ST_PX;
                end
            end
            ST_PX:   begin cmd.op = OP_PIX_X; state_next = ST_PY; end
            ST_PY:
            begin
                cmd.op       = OP_PIX_Y;
                div_cnt_next = '0;
                state_next   = stat.at_limit ? ST_WRITE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op       = OP_DIV;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_W'(DIV_STEPS - 1))
                    state_next = ST_UT;
            end
            ST_UT: begin cmd.op = OP_UT; state_next = ST_TT; end
            ST_TT: begin cmd.op = OP_TT; state_next = ST_UU; end
            ST_UU: begin cmd.op = OP_UU; state_next = ST_PR; end
            ST_PR: begin cmd.op = OP_PR; state_next = ST_PG; end
            ST_PG: begin cmd.op = OP_PG; state_next = ST_PB; end
            ST_PB: begin cmd.op = OP_PB; state_next = ST_CR; end
            ST_CR: begin cmd.op = OP_CR; state_next = ST_CG; end
            ST_CG: begin cmd.op = OP_CG; state_next = ST_CB; end
            ST_CB: begin cmd.op = OP_CB; state_next = ST_WRITE; end
            ST_WRITE:
            begin
                cmd.load_out = !out_valid_reg || m_tready;
                if (cmd.load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // set on load, drop after the output transfer
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

FILE: rtl/mandelbrot_orbit_plotter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_orbit_plotter
// Iterates z = z*z + c in Q4.27 and emits one plot result per input item.
// ----------------------------------------------------------------------------
// One item is worked at a time and every item yields one result. A start item
// or a step with no active orbit goes straight to the output register;
// escaping, limit-reaching and colored steps end after the escape test, the
// pixel map and color polynomial, on one 34x34 multiplier used once per cycle
// and a restoring divider that produces one bit of t per cycle. A finished
// result waits in the output register while the next item is taken.
module mandelbrot_orbit_plotter (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // point_real[31:0], point_imag[63:32]
    input  wire  [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // pixel_x[11:0], pixel_y[23:12], color[47:24]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast    // orbit_done
);
    import mop_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic [11:0] out_x, out_y;
    logic [23:0] out_color;

    mop_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mop_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_real    (s_tdata[31:0]),
        .in_imag    (s_tdata[63:32]),
        .out_status (m_tuser),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_color  (out_color),
        .out_done   (m_tlast)
    );

    assign m_tdata = {out_color, out_y, out_x};

endmodule
`default_nettype wire
